>>> rtl/lshb_pkg.sv
// Shared types, constants and letter decode for the letter string hash block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package lshb_pkg;

  localparam int CharW   = 8;
  localparam int ValW    = 6;
  localparam int PowW    = 24;
  localparam int HashW   = 30;
  localparam int BucketW = 16;
  localparam int ProdW   = ValW + PowW;
  localparam int QW      = 6;
  localparam int BitW    = 5;
  localparam int SumW    = HashW + 2;
  localparam int RecipW  = 15;
  localparam int RecipSh = 32;
  localparam int QProdW  = PowW + RecipW;

  localparam logic [HashW-1:0] SumMod   = 30'd999999991;
  localparam logic [PowW-1:0]  PowMod   = 24'd9999991;
  localparam logic [63:0]      RecipAll = (64'd52 << RecipSh) / 64'd9999991;
  localparam logic [RecipW-1:0] Recip   = RecipAll[RecipW-1:0];

  localparam logic [CharW-1:0] UpperFirst = 8'd65;
  localparam logic [CharW-1:0] UpperLast  = 8'd90;
  localparam logic [CharW-1:0] LowerFirst = 8'd97;
  localparam logic [CharW-1:0] LowerLast  = 8'd122;
  localparam logic [CharW-1:0] LowerOff   = 8'd71;

  localparam logic [BucketW-1:0] BucketReset = 16'd100;

  typedef struct packed {
    logic            load;
    logic            update;
    logic            div_clear;
    logic            div_step;
    logic [BitW-1:0] div_bit;
    logic            finish;
  } cmd_t;

  function automatic logic is_letter(input logic [CharW-1:0] code);
    is_letter = (code >= UpperFirst && code <= UpperLast) ||
                (code >= LowerFirst && code <= LowerLast);
  endfunction

  function automatic logic [ValW-1:0] letter_value(input logic [CharW-1:0] code);
    logic [CharW-1:0] v;
    if (code <= UpperLast) begin
      v = code - UpperFirst;
    end else begin
      v = code - LowerOff;
    end
    letter_value = v[ValW-1:0];
  endfunction

endpackage

>>> rtl/lshb_datapath.sv
// Datapath: running sum and place power with modular reduction, bit-serial
// bucket remainder, config register and output payload. Uses lshb_pkg.
`timescale 1ns / 1ps

module lshb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lshb_pkg::cmd_t                cmd,
  input  logic [lshb_pkg::CharW-1:0]    char_code,
  input  logic                          cfg_valid,
  input  logic [lshb_pkg::BucketW-1:0]  bucket_count,
  output logic [lshb_pkg::HashW-1:0]    hash_value,
  output logic [lshb_pkg::BucketW-1:0]  bucket_index,
  output logic                          bad_char
);

  logic [lshb_pkg::BucketW-1:0] buckets;
  logic [lshb_pkg::HashW-1:0]   sum;
  logic [lshb_pkg::PowW-1:0]    power;
  logic                         err;
  logic                         letter;
  logic [lshb_pkg::ProdW-1:0]   prod;
  logic [lshb_pkg::HashW-1:0]   x52;
  logic [lshb_pkg::QW-1:0]      q;
  logic [lshb_pkg::BucketW-1:0] rem;

  logic [lshb_pkg::ValW-1:0]    val;
  logic [lshb_pkg::ProdW-1:0]   vp;
  logic [lshb_pkg::QProdW-1:0]  qp;
  logic [lshb_pkg::HashW-1:0]   pw_ext;
  logic [lshb_pkg::SumW-1:0]    s;
  logic [lshb_pkg::SumW-1:0]    m1;
  logic [lshb_pkg::SumW-1:0]    m2;
  logic [lshb_pkg::HashW-1:0]   sum_next;
  logic [lshb_pkg::HashW-1:0]   qpm;
  logic [lshb_pkg::HashW-1:0]   r;
  logic [lshb_pkg::HashW-1:0]   pmod_ext;
  logic [lshb_pkg::PowW-1:0]    power_next;
  logic [lshb_pkg::BucketW:0]   t;
  logic [lshb_pkg::BucketW-1:0] rem_next;

  always_comb begin
    val    = lshb_pkg::letter_value(char_code);
    vp     = lshb_pkg::ProdW'(val) * lshb_pkg::ProdW'(power);
    qp     = lshb_pkg::QProdW'(power) * lshb_pkg::QProdW'(lshb_pkg::Recip);
    pw_ext = lshb_pkg::HashW'(power);

    s  = {1'b0, sum, 1'b0} + lshb_pkg::SumW'(prod);
    m1 = lshb_pkg::SumW'(lshb_pkg::SumMod);
    m2 = m1 << 1;
    if (s >= m2) begin
      sum_next = lshb_pkg::HashW'(s - m2);
    end else if (s >= m1) begin
      sum_next = lshb_pkg::HashW'(s - m1);
    end else begin
      sum_next = s[lshb_pkg::HashW-1:0];
    end

    pmod_ext = lshb_pkg::HashW'(lshb_pkg::PowMod);
    qpm      = lshb_pkg::HashW'(q) * pmod_ext;
    r        = x52 - qpm;
    if (r >= pmod_ext) begin
      power_next = lshb_pkg::PowW'(r - pmod_ext);
    end else begin
      power_next = r[lshb_pkg::PowW-1:0];
    end

    t = {rem, sum[cmd.div_bit]};
    if (t >= {1'b0, buckets}) begin
      rem_next = lshb_pkg::BucketW'(t - {1'b0, buckets});
    end else begin
      rem_next = t[lshb_pkg::BucketW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buckets <= lshb_pkg::BucketReset;
      sum     <= '0;
      power   <= lshb_pkg::PowW'(1);
      err     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        buckets <= bucket_count;
      end
      if (cmd.load && !lshb_pkg::is_letter(char_code)) begin
        err <= 1'b1;
      end
      if (cmd.update && letter) begin
        sum   <= sum_next;
        power <= power_next;
      end
      if (cmd.finish) begin
        sum   <= '0;
        power <= lshb_pkg::PowW'(1);
        err   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      letter <= lshb_pkg::is_letter(char_code);
      prod   <= vp;
      x52    <= (pw_ext << 5) + (pw_ext << 4) + (pw_ext << 2);
      q      <= qp[lshb_pkg::RecipSh +: lshb_pkg::QW];
    end
    if (cmd.div_clear) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.finish) begin
      hash_value   <= sum;
      bucket_index <= (buckets == '0) ? '0 : rem;
      bad_char     <= err;
    end
  end

endmodule

>>> rtl/lshb_ctrl.sv
// Controller: sequences load, update, bit-serial remainder and result hand-off.
// Uses lshb_pkg; drives lshb_datapath through cmd_t.
`timescale 1ns / 1ps

module lshb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           last,
  output logic           out_valid,
  input  logic           out_ready,
  output lshb_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                     state;
  logic                       last_r;
  logic [lshb_pkg::BitW-1:0]  cnt;
  logic                       accept;
  logic                       emit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.update    = (state == ST_UPD);
    cmd.div_clear = (state == ST_UPD) && last_r;
    cmd.div_step  = (state == ST_DIV);
    cmd.div_bit   = cnt;
    cmd.finish    = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_r    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_r <= last;
            state  <= ST_UPD;
          end
        end
        ST_UPD: begin
          cnt   <= lshb_pkg::BitW'(lshb_pkg::HashW - 1);
          state <= last_r ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_FIN: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/letter_string_hash_bucket.sv
// Top level of the letter string hash: joins lshb_ctrl and lshb_datapath.
// Uses lshb_pkg.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    char_code[7:0], last
//   out      source     out_valid / out_ready  hash_value[29:0], bucket_index[15:0], bad_char
//   cfg      sink       cfg_valid / cfg_ready  bucket_count[15:0]
//
// Each character: operand products on acceptance, then the modular update in ST_UPD.
// A last character then runs the bit-serial bucket remainder over the 30 hash bits (one
// quotient bit per cycle), and ST_FIN loads the output register once the slot is free.
// Reset: bucket count 100, sum 0, power 1, no error, no result pending.
// The result register holds while out_ready is low; the next key's characters
// are still taken, and a following result waits in ST_FIN for the free slot.
`timescale 1ns / 1ps

module letter_string_hash_bucket (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lshb_pkg::CharW-1:0]    char_code,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lshb_pkg::HashW-1:0]    hash_value,
  output logic [lshb_pkg::BucketW-1:0]  bucket_index,
  output logic                          bad_char,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lshb_pkg::BucketW-1:0]  bucket_count
);

  lshb_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  lshb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lshb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .char_code    (char_code),
    .cfg_valid    (cfg_valid),
    .bucket_count (bucket_count),
    .hash_value   (hash_value),
    .bucket_index (bucket_index),
    .bad_char     (bad_char)
  );

endmodule

>>> rtl/lshb_checker.sv
// Port-level checks for letter_string_hash_bucket, bound to the top level.
// Uses lshb_pkg.
`timescale 1ns / 1ps

module lshb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lshb_pkg::HashW-1:0]    hash_value,
  input logic [lshb_pkg::BucketW-1:0]  bucket_index,
  input logic                          bad_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value) &&
      $stable(bucket_index) && $stable(bad_char))
    else $error("result beat changed while stalled");

  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hash_value < lshb_pkg::SumMod)
    else $error("hash_value not reduced");

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while update in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind letter_string_hash_bucket lshb_checker u_lshb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hash_value   (hash_value),
  .bucket_index (bucket_index),
  .bad_char     (bad_char)
);
